/* sv/assert_macros.svh */
// Assertion helpers shared by the RTL files.
// All checks sample on i_clk and are off while i_rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition holds on every sampled edge.
`define SBL_ASSERT(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) else $error(msg);

// Consequent holds in the same cycle as the antecedent.
`define SBL_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define SBL_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* sv/sbl_pkg.sv */
`timescale 1ns / 1ps

package sbl_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int WIDTH_W    = 11;
    localparam int ROW_W      = 16;
    localparam int PIX_W      = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int RAD_W      = 2 * PIX_W + 1;
    localparam int ROOT_W     = (RAD_W + 1) / 2;

    typedef logic [PIX_W-1:0]      t_pix;
    typedef logic [ROW_W-1:0]      t_row;
    typedef logic [COL_W-1:0]      t_col;
    typedef logic [WIDTH_W-1:0]    t_width;
    typedef logic [CFG_IDX_W-1:0]  t_cfg_idx;
    typedef logic [CFG_DATA_W-1:0] t_cfg_data;

    // One line-store word: row two above and row just above.
    typedef struct packed {
        t_pix upper;
        t_pix lower;
    } t_line_pair;

    // Register indexes on the config port
    localparam t_cfg_idx CFG_IMAGE_WIDTH  = CFG_IDX_W'(0);
    localparam t_cfg_idx CFG_IMAGE_HEIGHT = CFG_IDX_W'(1);
    localparam t_cfg_idx CFG_COMBINE_MODE = CFG_IDX_W'(2);

    localparam t_width WIDTH_RESET  = WIDTH_W'(MAX_WIDTH);
    localparam t_row   HEIGHT_RESET = ROW_W'(480);
    localparam t_width WIDTH_MIN    = WIDTH_W'(3);
    localparam t_row   HEIGHT_MIN   = ROW_W'(3);
    localparam t_pix   PIX_MAX      = {PIX_W{1'b1}};

endpackage

/* sv/sbl_if.sv */
`timescale 1ns / 1ps

interface sbl_pix_if;
    logic          valid;
    logic          ready;
    sbl_pkg::t_pix pixel_in;

    modport source (output valid, output pixel_in, input ready);
    modport sink   (input valid, input pixel_in, output ready);
endinterface

interface sbl_edge_if;
    logic          valid;
    logic          ready;
    sbl_pkg::t_pix edge_value;
    sbl_pkg::t_row out_row;
    sbl_pkg::t_col out_col;
    logic          last_of_run;

    modport source (output valid, output edge_value, output out_row, output out_col,
                    output last_of_run, input ready);
    modport sink   (input valid, input edge_value, input out_row, input out_col,
                    input last_of_run, output ready);
endinterface

interface sbl_cfg_if;
    logic               valid;
    logic               ready;
    sbl_pkg::t_cfg_idx  index;
    sbl_pkg::t_cfg_data data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

/* sv/sbl_line_mem.sv */
`timescale 1ns / 1ps

// Both line stores in one word-wide single-port-per-direction RAM.
module sbl_line_mem (
    input  logic                i_clk,
    input  logic                i_rd_en,
    input  sbl_pkg::t_col       i_rd_addr,
    output sbl_pkg::t_line_pair o_rd_data,
    input  logic                i_wr_en,
    input  sbl_pkg::t_col       i_wr_addr,
    input  sbl_pkg::t_line_pair i_wr_data
);

    sbl_pkg::t_line_pair r_mem [sbl_pkg::MAX_WIDTH];
    sbl_pkg::t_line_pair r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

/* sv/sbl_grad.sv */
`timescale 1ns / 1ps

// Two-column window plus the Sobel sums for the current column.
module sbl_grad (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_shift,
    input  sbl_pkg::t_pix i_top,
    input  sbl_pkg::t_pix i_mid,
    input  sbl_pkg::t_pix i_pix,
    output sbl_pkg::t_pix o_gx,
    output sbl_pkg::t_pix o_gy
);

    localparam int SUM_W = sbl_pkg::PIX_W + 3;

    typedef logic [SUM_W-2:0] t_tap;

    // column c-1 and column c-2
    sbl_pkg::t_pix r_t1, r_m1, r_b1;
    sbl_pkg::t_pix r_t0, r_m0, r_b0;

    function automatic t_tap tap_sum(sbl_pkg::t_pix a, sbl_pkg::t_pix b, sbl_pkg::t_pix c);
        tap_sum = t_tap'(a) + (t_tap'(b) << 1) + t_tap'(c);
    endfunction

    // |s| / 4, round half to even, clamp
    function automatic sbl_pkg::t_pix grad_scale(logic signed [SUM_W-1:0] s);
        logic [SUM_W-1:0]         mag;
        logic [sbl_pkg::PIX_W:0]  q;
        logic                     up;
        mag = s[SUM_W-1] ? SUM_W'(-s) : SUM_W'(s);
        up  = (mag[1:0] == 2'd3) || ((mag[1:0] == 2'd2) && mag[2]);
        q   = (sbl_pkg::PIX_W + 1)'(mag[SUM_W-1:2]) + (sbl_pkg::PIX_W + 1)'(up);
        grad_scale = q[sbl_pkg::PIX_W] ? sbl_pkg::PIX_MAX : q[sbl_pkg::PIX_W-1:0];
    endfunction

    t_tap                    px, nx, py, ny;
    logic signed [SUM_W-1:0] sx, sy;

    assign px = tap_sum(i_top, i_mid, i_pix);
    assign nx = tap_sum(r_t0, r_m0, r_b0);
    assign py = tap_sum(r_b0, r_b1, i_pix);
    assign ny = tap_sum(r_t0, r_t1, i_top);
    assign sx = $signed({1'b0, px}) - $signed({1'b0, nx});
    assign sy = $signed({1'b0, py}) - $signed({1'b0, ny});

    assign o_gx = grad_scale(sx);
    assign o_gy = grad_scale(sy);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_t1 <= '0;
            r_m1 <= '0;
            r_b1 <= '0;
            r_t0 <= '0;
            r_m0 <= '0;
            r_b0 <= '0;
        end else if (i_shift) begin
            r_t0 <= r_t1;
            r_m0 <= r_m1;
            r_b0 <= r_b1;
            r_t1 <= i_top;
            r_m1 <= i_mid;
            r_b1 <= i_pix;
        end
    end

endmodule

/* sv/sbl_isqrt.sv */
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Digit-by-digit integer square root, one result bit per cycle.
module sbl_isqrt (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [sbl_pkg::RAD_W-1:0]    i_radicand,
    output logic                         o_done,
    output logic [sbl_pkg::ROOT_W-1:0]   o_root
);

    localparam int RW    = sbl_pkg::ROOT_W;
    localparam int CNT_W = $clog2(RW + 1);
    localparam int REM_W = RW + 2;
    localparam int CUR_W = REM_W + 2;

    logic              r_busy;
    logic              r_done;
    logic [CNT_W-1:0]  r_cnt;
    logic [2*RW-1:0]   r_rad;
    logic [REM_W-1:0]  r_rem;
    logic [RW-1:0]     r_root;

    logic [CUR_W-1:0]  cur;
    logic [CUR_W-1:0]  trial;
    logic              fits;

    assign cur   = {r_rem, r_rad[2*RW-1 -: 2]};
    assign trial = {2'b00, r_root, 2'b01};
    assign fits  = (cur >= trial);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            // done pulses for one cycle after the last digit
            r_done <= !i_start && r_busy && (r_cnt == CNT_W'(1));
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(RW);
                r_rad  <= (2 * RW)'(i_radicand);
                r_rem  <= '0;
                r_root <= '0;
            end else if (r_busy) begin
                r_rad  <= r_rad << 2;
                r_rem  <= fits ? REM_W'(cur - trial) : REM_W'(cur);
                r_root <= {r_root[RW-2:0], fits};
                r_cnt  <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_root = r_root;

    `SBL_ASSERT_IMPL(a_start_when_free, i_start, !r_busy, "sqrt restarted while busy")
    `SBL_ASSERT_IMPL(a_done_ends_run, r_done, !r_busy && $past(r_busy), "stray sqrt done")

endmodule

/* sv/sobel_edge_magnitude.sv */
`timescale 1ns / 1ps
`include "assert_macros.svh"
// 3x3 Sobel edge magnitude over a raster-order 8-bit grayscale stream.
// i_pix  : one pixel per request; row and column are tracked inside.
// o_edge : edge_value with out_row/out_col of the pixel it belongs to;
//          last_of_run marks the final result caused by one pixel.
// i_cfg  : index 0 image_width, 1 image_height (both restart the frame),
//          2 combine_mode (0 sqrt(gx^2+gy^2), 1 gx+gy). Write while idle.
// A pixel at (r,c) yields the interior result for (r-1,c-1) when r>=2 and
// c>=2, then its own result when it lies on the frame border: 0..2 results.
// Timing: one pixel at a time. Accept and line-store read come first, then
// per result: in mode 0 start of the 9-step shared root unit and emit,
// or the sum and emit in mode 1.
// The output register decouples the sides: the next pixel is accepted
// while the last result still waits; a stalled receiver only holds the
// block once another result must be loaded.
// Reset (synchronous, active low): registers to width 1024, height 480,
// mode 0, position (0,0), window cleared, output empty. No RAM clear.
module sobel_edge_magnitude (
    input  logic              i_clk,
    input  logic              i_rst_n,
    sbl_pix_if.sink           i_pix,
    sbl_edge_if.source        o_edge,
    sbl_cfg_if.sink           i_cfg
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_CALC,
        ST_ROOT,
        ST_EMIT
    } t_state;

    t_state r_state;

    // configuration and raster position
    sbl_pkg::t_width r_width;
    sbl_pkg::t_row   r_height;
    logic            r_mode;
    sbl_pkg::t_row   r_row;
    sbl_pkg::t_col   r_col;

    // pixel being worked on
    sbl_pkg::t_pix   r_pix;
    sbl_pkg::t_row   r_item_row;
    sbl_pkg::t_col   r_item_col;
    logic            r_has_int;
    logic            r_has_bdr;

    // result being formed
    sbl_pkg::t_pix   r_opa, r_opb;
    sbl_pkg::t_row   r_res_row;
    sbl_pkg::t_col   r_res_col;
    logic            r_res_last;
    logic            r_pend_bdr;
    sbl_pkg::t_pix   r_value;

    // output register
    logic            r_out_valid;
    sbl_pkg::t_pix   r_out_value;
    sbl_pkg::t_row   r_out_row;
    sbl_pkg::t_col   r_out_col;
    logic            r_out_last;

    sbl_pkg::t_width w_eff;
    sbl_pkg::t_row   h_eff;
    sbl_pkg::t_width col_ext;
    logic            pix_acc;
    logic            cfg_acc;
    logic            at_int;
    logic            at_bdr;
    logic            out_free;

    sbl_pkg::t_line_pair rd_pair;
    sbl_pkg::t_line_pair wr_pair;
    sbl_pkg::t_pix       gx, gy;

    logic [2*sbl_pkg::PIX_W-1:0]  sq_a, sq_b;
    logic [sbl_pkg::RAD_W-1:0]    radicand;
    logic [sbl_pkg::PIX_W:0]      sum_ab;
    logic [sbl_pkg::ROOT_W-1:0]   root;
    logic                         sqrt_start;
    logic                         sqrt_done;

    logic [sbl_pkg::WIDTH_W-1:0]  n_col_ext;
    logic [sbl_pkg::ROW_W:0]      n_row_ext;

    // effective geometry: width clamped to 3..MAX_WIDTH, height at least 3
    assign w_eff = (r_width < sbl_pkg::WIDTH_MIN) ? sbl_pkg::WIDTH_MIN :
                   (r_width > sbl_pkg::WIDTH_RESET) ? sbl_pkg::WIDTH_RESET : r_width;
    assign h_eff = (r_height < sbl_pkg::HEIGHT_MIN) ? sbl_pkg::HEIGHT_MIN : r_height;

    assign col_ext = sbl_pkg::WIDTH_W'(r_col);
    assign pix_acc = i_pix.valid && i_pix.ready;
    assign cfg_acc = i_cfg.valid && i_cfg.ready;

    assign at_int = (r_row >= sbl_pkg::ROW_W'(2)) && (r_col >= sbl_pkg::COL_W'(2));
    assign at_bdr = (r_row == '0) || (r_row >= h_eff - sbl_pkg::ROW_W'(1)) ||
                    (r_col == '0) || (col_ext >= w_eff - sbl_pkg::WIDTH_W'(1));

    assign out_free = !r_out_valid || o_edge.ready;

    assign i_pix.ready = (r_state == ST_IDLE);
    assign i_cfg.ready = 1'b1;

    // Line stores: read column c on accept, write back {mid, pixel} next cycle.
    assign wr_pair.upper = rd_pair.lower;
    assign wr_pair.lower = r_pix;

    sbl_line_mem u_line_mem (
        .i_clk     (i_clk),
        .i_rd_en   (pix_acc),
        .i_rd_addr (r_col),
        .o_rd_data (rd_pair),
        .i_wr_en   (r_state == ST_READ),
        .i_wr_addr (r_item_col),
        .i_wr_data (wr_pair)
    );

    sbl_grad u_grad (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_shift (r_state == ST_READ),
        .i_top   (rd_pair.upper),
        .i_mid   (rd_pair.lower),
        .i_pix   (r_pix),
        .o_gx    (gx),
        .o_gy    (gy)
    );

    // Combine stage: squares feed the shared root unit, or a plain sum.
    assign sq_a       = r_opa * r_opa;
    assign sq_b       = r_opb * r_opb;
    assign radicand   = {1'b0, sq_a} + {1'b0, sq_b};
    assign sum_ab     = {1'b0, r_opa} + {1'b0, r_opb};
    assign sqrt_start = (r_state == ST_CALC) && !r_mode;

    sbl_isqrt u_isqrt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (sqrt_start),
        .i_radicand (radicand),
        .o_done     (sqrt_done),
        .o_root     (root)
    );

    // Raster position advance, one step per pixel
    assign n_col_ext = col_ext + sbl_pkg::WIDTH_W'(1);
    assign n_row_ext = {1'b0, r_row} + (sbl_pkg::ROW_W + 1)'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= sbl_pkg::WIDTH_RESET;
            r_height <= sbl_pkg::HEIGHT_RESET;
            r_mode   <= 1'b0;
            r_row    <= '0;
            r_col    <= '0;
        end else if (cfg_acc) begin
            unique case (i_cfg.index)
                sbl_pkg::CFG_IMAGE_WIDTH: begin
                    r_width <= i_cfg.data[sbl_pkg::WIDTH_W-1:0];
                    r_row   <= '0;
                    r_col   <= '0;
                end
                sbl_pkg::CFG_IMAGE_HEIGHT: begin
                    r_height <= i_cfg.data;
                    r_row    <= '0;
                    r_col    <= '0;
                end
                sbl_pkg::CFG_COMBINE_MODE: begin
                    r_mode <= i_cfg.data[0];
                end
                default: begin
                end
            endcase
        end else if (r_state == ST_READ) begin
            if (n_col_ext >= w_eff) begin
                r_col <= '0;
                if (n_row_ext >= {1'b0, h_eff}) begin
                    r_row <= '0;
                end else begin
                    r_row <= n_row_ext[sbl_pkg::ROW_W-1:0];
                end
            end else begin
                r_col <= n_col_ext[sbl_pkg::COL_W-1:0];
            end
        end
    end

    // Main sequencer and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            // load a new result, or drop the one the receiver took
            if ((r_state == ST_EMIT) && out_free) begin
                r_out_valid <= 1'b1;
            end else if (o_edge.ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (pix_acc) begin
                        r_pix      <= i_pix.pixel_in;
                        r_item_row <= r_row;
                        r_item_col <= r_col;
                        r_has_int  <= at_int;
                        r_has_bdr  <= at_bdr;
                        r_state    <= ST_READ;
                    end
                end
                ST_READ: begin
                    // interior result for (r-1,c-1) goes first
                    priority if (r_has_int) begin
                        r_opa      <= gx;
                        r_opb      <= gy;
                        r_res_row  <= r_item_row - sbl_pkg::ROW_W'(1);
                        r_res_col  <= r_item_col - sbl_pkg::COL_W'(1);
                        r_res_last <= !r_has_bdr;
                        r_pend_bdr <= r_has_bdr;
                        r_state    <= ST_CALC;
                    end else if (r_has_bdr) begin
                        r_opa      <= r_pix;
                        r_opb      <= r_pix;
                        r_res_row  <= r_item_row;
                        r_res_col  <= r_item_col;
                        r_res_last <= 1'b1;
                        r_pend_bdr <= 1'b0;
                        r_state    <= ST_CALC;
                    end else begin
                        r_state <= ST_IDLE;
                    end
                end
                ST_CALC: begin
                    if (r_mode) begin
                        r_value <= sum_ab[sbl_pkg::PIX_W] ? sbl_pkg::PIX_MAX :
                                   sum_ab[sbl_pkg::PIX_W-1:0];
                        r_state <= ST_EMIT;
                    end else begin
                        r_state <= ST_ROOT;
                    end
                end
                ST_ROOT: begin
                    if (sqrt_done) begin
                        r_value <= (root > sbl_pkg::ROOT_W'(sbl_pkg::PIX_MAX)) ?
                                   sbl_pkg::PIX_MAX : root[sbl_pkg::PIX_W-1:0];
                        r_state <= ST_EMIT;
                    end
                end
                ST_EMIT: begin
                    if (out_free) begin
                        r_out_value <= r_value;
                        r_out_row   <= r_res_row;
                        r_out_col   <= r_res_col;
                        r_out_last  <= r_res_last;
                        if (r_pend_bdr) begin
                            r_opa      <= r_pix;
                            r_opb      <= r_pix;
                            r_res_row  <= r_item_row;
                            r_res_col  <= r_item_col;
                            r_res_last <= 1'b1;
                            r_pend_bdr <= 1'b0;
                            r_state    <= ST_CALC;
                        end else begin
                            r_state <= ST_IDLE;
                        end
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_edge.valid       = r_out_valid;
    assign o_edge.edge_value  = r_out_value;
    assign o_edge.out_row     = r_out_row;
    assign o_edge.out_col     = r_out_col;
    assign o_edge.last_of_run = r_out_last;

    `SBL_ASSERT_NEXT(a_accept_reads, pix_acc, r_state == ST_READ, "accept did not start read")
    `SBL_ASSERT(a_col_in_range, col_ext < w_eff, "column counter beyond row width")
    `SBL_ASSERT_IMPL(a_root_when_waiting, sqrt_done, r_state == ST_ROOT, "root done while not waiting")

endmodule
